FILE: design/kljs_pkg.sv
package kljs_pkg;

	localparam int LOG_X_W = 40;
	localparam int LN_W = 33;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_WEIGHT_FIRST = 2'd1;
	localparam logic [1:0] CFG_WEIGHT_SECOND = 2'd2;
	localparam logic [1:0] CFG_SUM_TOLERANCE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FIRST_BAD = 3'd1;
	localparam logic [2:0] ST_SECOND_BAD = 3'd2;
	localparam logic [2:0] ST_BAD_WEIGHTS = 3'd3;
	localparam logic [2:0] ST_INFINITE = 3'd4;
	localparam logic [2:0] ST_NEGATIVE = 3'd5;

	typedef struct packed {
		logic start;
		logic [LOG_X_W-1:0] x;
	} log_req_t;

	typedef struct packed {
		logic done;
		logic [LN_W-1:0] value;
	} log_rsp_t;

endpackage

FILE: design/kljs_in_if.sv
interface kljs_in_if;
	logic valid;
	logic ready;
	logic [16:0] p_element;
	logic [16:0] q_element;
	logic last_element;

	modport source(output valid, output p_element, output q_element, output last_element,
		input ready);
	modport sink(input valid, input p_element, input q_element, input last_element,
		output ready);
endinterface

FILE: design/kljs_out_if.sv
interface kljs_out_if;
	logic valid;
	logic ready;
	logic [31:0] divergence;
	logic [2:0] status;

	modport source(output valid, output divergence, output status, input ready);
	modport sink(input valid, input divergence, input status, output ready);
endinterface

FILE: design/kljs_log.sv
module kljs_log import kljs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input log_req_t req,
	output log_rsp_t rsp
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_NORM = 3'd1;
	localparam logic [2:0] L_SQR = 3'd2;
	localparam logic [2:0] L_MUL = 3'd3;
	localparam logic [2:0] L_DONE = 3'd4;

	logic [2:0] st_q;
	logic [LOG_X_W-1:0] y_q;
	logic [5:0] e_q;
	logic [31:0] mant_q;
	logic [27:0] frac_q;
	logic [4:0] i_q;
	logic [LN_W-1:0] res_q;
	logic [63:0] sq;
	logic [32:0] t;
	logic [63:0] prod;

	assign sq = 64'(mant_q) * 64'(mant_q);
	assign t = sq[63:31];
	assign prod = 64'({e_q, frac_q}) * 64'(LN2_Q30) + 64'd536870912;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
		end else begin
			case (st_q)
				L_IDLE: if (req.start) st_q <= (req.x == '0) ? L_DONE : L_NORM;
				L_NORM: if (y_q[LOG_X_W-1]) st_q <= L_SQR;
				L_SQR: if (i_q == 5'd0) st_q <= L_MUL;
				L_MUL: st_q <= L_DONE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				y_q <= req.x;
				e_q <= 6'(LOG_X_W - 1);
				res_q <= '0;
			end
			L_NORM: begin
				if (y_q[LOG_X_W-1]) begin
					mant_q <= y_q[LOG_X_W-1 -: 32];
					frac_q <= '0;
					i_q <= 5'd27;
				end else begin
					y_q <= {y_q[LOG_X_W-2:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			L_SQR: begin
				if (t[32]) begin
					mant_q <= t[32:1];
					frac_q[i_q] <= 1'b1;
				end else begin
					mant_q <= t[31:0];
				end
				i_q <= i_q - 5'd1;
			end
			L_MUL: res_q <= prod[30 +: LN_W];
			default: ;
		endcase
	end

	assign rsp.done = (st_q == L_DONE);
	assign rsp.value = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> st_q == L_IDLE) else $error("log start while busy");
	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == L_IDLE && req.start && req.x == '0) |=> rsp.done && rsp.value == '0)
		else $error("log of zero not immediate");
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q == L_SQR) |-> mant_q[31]) else $error("mantissa not normalized");

endmodule

FILE: design/kl_js_divergence.sv
// Channel | Dir | Payload                                   | Transaction
// in_ch   | in  | p_element, q_element, last_element        | valid & ready
// out_ch  | out | divergence, status                        | valid & ready
// cfg     | in  | cfg_we, cfg_index, cfg_data               | cfg_we high
// The shared log unit normalizes each input, then does 28 squarings and a scaling multiply per
// logarithm; a KL pair needs up to two logarithms and a JS pair up to three.
// Reset clears the configuration to its defaults and all per-vector sums.
// A result waits in the output register; a following last pair stalls until it is taken.
module kl_js_divergence import kljs_pkg::*; #(
	parameter int MAX_LENGTH = 1024
) (
	input logic clk,
	input logic arst_n,
	kljs_in_if.sink in_ch,
	kljs_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [16:0] cfg_data
);

	localparam logic [63:0] SUM_MAX = 64'(MAX_LENGTH) * 64'd131071;
	localparam int SUM_W = $clog2(MAX_LENGTH * 64'd131071 + 64'd1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_KL_LA = 4'd2;
	localparam logic [3:0] S_KL_LB = 4'd3;
	localparam logic [3:0] S_JS_LM_S = 4'd4;
	localparam logic [3:0] S_JS_LM_W = 4'd5;
	localparam logic [3:0] S_JS_T1 = 4'd6;
	localparam logic [3:0] S_JS_T1_W = 4'd7;
	localparam logic [3:0] S_JS_T2 = 4'd8;
	localparam logic [3:0] S_JS_T2_W = 4'd9;
	localparam logic [3:0] S_TERM = 4'd10;
	localparam logic [3:0] S_TERM2 = 4'd11;
	localparam logic [3:0] S_TERM3 = 4'd12;
	localparam logic [3:0] S_FIN = 4'd13;
	localparam logic [3:0] S_KL_LB_S = 4'd14;

	logic [3:0] state_q, ret_q;
	logic mode_q;
	logic [16:0] w1_q, w2_q;
	logic [15:0] tol_q;
	logic [16:0] p_q, q_q;
	logic last_q, imode_q;
	logic [33:0] w1p_q, w2q_q;
	logic [34:0] m_q;
	logic [LN_W-1:0] lnm_q, la_q, lb_q, d_q;
	logic [17:0] coef_q;
	logic neg_q;
	logic [50:0] prod_q;
	logic signed [55:0] acc_q;
	logic zds_q;
	logic [SUM_W-1:0] sum1_q, sum2_q;
	logic ovalid_q;
	logic [31:0] odiv_q;
	logic [2:0] ostat_q;

	log_req_t lreq;
	log_rsp_t lrsp;

	logic [SUM_W:0] s1_add, s2_add;
	logic [34:0] c1_sum, c2_sum;
	logic [39:0] mag;
	logic signed [56:0] s57;
	logic [56:0] rnd;
	logic [40:0] r;
	logic [2:0] fstat;
	logic [31:0] fdiv;
	logic out_free;
	logic res_fire;

	function automatic logic off_one(input logic [63:0] s, input logic [15:0] tol);
		return (s > 64'(ONE_Q16) + 64'(tol)) || (s + 64'(tol) < 64'(ONE_Q16));
	endfunction

	kljs_log u_log (.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp));

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.divergence = odiv_q;
	assign out_ch.status = ostat_q;
	assign out_free = !ovalid_q || out_ch.ready;
	assign res_fire = (state_q == S_FIN) && last_q && out_free;

	assign s1_add = {1'b0, sum1_q} + (SUM_W+1)'(in_ch.p_element);
	assign s2_add = {1'b0, sum2_q} + (SUM_W+1)'(in_ch.q_element);
	assign c1_sum = {1'b0, w1p_q} + 35'd32768;
	assign c2_sum = {1'b0, w2q_q} + 35'd32768;
	assign mag = 40'((52'(prod_q) + 52'd2048) >> 12);
	assign s57 = neg_q ? ({acc_q[55], acc_q} - $signed({17'b0, mag}))
		: ({acc_q[55], acc_q} + $signed({17'b0, mag}));
	assign rnd = {1'b0, acc_q} + 57'd32768;
	assign r = rnd[56:16];

	always_comb begin
		fdiv = '0;
		if (off_one(64'(sum1_q), tol_q)) begin
			fstat = ST_FIRST_BAD;
		end else if (off_one(64'(sum2_q), tol_q)) begin
			fstat = ST_SECOND_BAD;
		end else if (imode_q && off_one(64'(w1_q) + 64'(w2_q), tol_q)) begin
			fstat = ST_BAD_WEIGHTS;
		end else if (zds_q) begin
			fstat = ST_INFINITE;
			fdiv = '1;
		end else if (acc_q < 0) begin
			fstat = ST_NEGATIVE;
		end else begin
			fstat = ST_OK;
			fdiv = (r > 41'hFFFFFFFF) ? '1 : r[31:0];
		end
	end

	always_comb begin
		lreq = '0;
		case (state_q)
			S_DISPATCH: begin
				lreq.start = !imode_q && p_q != '0 && q_q != '0;
				lreq.x = LOG_X_W'(p_q);
			end
			S_KL_LB_S: begin
				lreq.start = 1'b1;
				lreq.x = LOG_X_W'(q_q);
			end
			S_JS_LM_S: begin
				lreq.start = 1'b1;
				lreq.x = LOG_X_W'(m_q);
			end
			S_JS_T1: begin
				lreq.start = w1_q != '0 && p_q != '0 && m_q != '0;
				lreq.x = LOG_X_W'({p_q, 16'b0});
			end
			S_JS_T2: begin
				lreq.start = w2_q != '0 && q_q != '0 && m_q != '0;
				lreq.x = LOG_X_W'({q_q, 16'b0});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			w1_q <= 17'd32768;
			w2_q <= 17'd32768;
			tol_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_WEIGHT_FIRST: w1_q <= cfg_data;
				CFG_WEIGHT_SECOND: w2_q <= cfg_data;
				CFG_SUM_TOLERANCE: tol_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			sum1_q <= '0;
			sum2_q <= '0;
			acc_q <= '0;
			zds_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (res_fire) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						sum1_q <= (64'(s1_add) > SUM_MAX) ? SUM_W'(SUM_MAX) : s1_add[SUM_W-1:0];
						sum2_q <= (64'(s2_add) > SUM_MAX) ? SUM_W'(SUM_MAX) : s2_add[SUM_W-1:0];
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (imode_q) begin
						state_q <= S_JS_LM_S;
					end else if (p_q == '0) begin
						state_q <= S_FIN;
					end else if (q_q == '0) begin
						zds_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_KL_LA;
					end
				end
				S_KL_LA: if (lrsp.done) state_q <= S_KL_LB_S;
				S_KL_LB_S: state_q <= S_KL_LB;
				S_KL_LB: begin
					if (lrsp.done) begin
						ret_q <= S_FIN;
						state_q <= S_TERM;
					end
				end
				S_JS_LM_S: state_q <= S_JS_LM_W;
				S_JS_LM_W: if (lrsp.done) state_q <= S_JS_T1;
				S_JS_T1: begin
					if (w1_q != '0 && p_q != '0) begin
						if (m_q == '0) begin
							zds_q <= 1'b1;
							state_q <= S_JS_T2;
						end else begin
							state_q <= S_JS_T1_W;
						end
					end else begin
						state_q <= S_JS_T2;
					end
				end
				S_JS_T1_W: begin
					if (lrsp.done) begin
						ret_q <= S_JS_T2;
						state_q <= S_TERM;
					end
				end
				S_JS_T2: begin
					if (w2_q != '0 && q_q != '0) begin
						if (m_q == '0) begin
							zds_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_JS_T2_W;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_JS_T2_W: begin
					if (lrsp.done) begin
						ret_q <= S_FIN;
						state_q <= S_TERM;
					end
				end
				S_TERM: state_q <= S_TERM2;
				S_TERM2: state_q <= S_TERM3;
				S_TERM3: begin
					if (s57[56] != s57[55]) begin
						acc_q <= s57[56] ? {1'b1, 55'b0} : {1'b0, {55{1'b1}}};
					end else begin
						acc_q <= s57[55:0];
					end
					state_q <= ret_q;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						sum1_q <= '0;
						sum2_q <= '0;
						acc_q <= '0;
						zds_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				p_q <= in_ch.p_element;
				q_q <= in_ch.q_element;
				last_q <= in_ch.last_element;
				imode_q <= mode_q;
				w1p_q <= 34'(w1_q) * 34'(in_ch.p_element);
				w2q_q <= 34'(w2_q) * 34'(in_ch.q_element);
			end
			S_DISPATCH: begin
				m_q <= {1'b0, w1p_q} + {1'b0, w2q_q};
				coef_q <= 18'(p_q);
			end
			S_KL_LA: if (lrsp.done) la_q <= lrsp.value;
			S_KL_LB: if (lrsp.done) lb_q <= lrsp.value;
			S_JS_LM_W: if (lrsp.done) lnm_q <= lrsp.value;
			S_JS_T1: coef_q <= c1_sum[33:16];
			S_JS_T2: coef_q <= c2_sum[33:16];
			S_JS_T1_W, S_JS_T2_W: begin
				if (lrsp.done) begin
					la_q <= lrsp.value;
					lb_q <= lnm_q;
				end
			end
			S_TERM: begin
				neg_q <= la_q < lb_q;
				d_q <= (la_q < lb_q) ? lb_q - la_q : la_q - lb_q;
			end
			S_TERM2: prod_q <= 51'(coef_q) * 51'(d_q);
			S_FIN: begin
				if (last_q && out_free) begin
					odiv_q <= fdiv;
					ostat_q <= fstat;
				end
			end
			default: ;
		endcase
	end

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == S_FIN)) else $error("result outside finish");
	a_inf_value: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && ostat_q == ST_INFINITE) |-> odiv_q == '1) else $error("bad infinite value");
	a_log_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lrsp.done |-> (state_q == S_KL_LA || state_q == S_KL_LB || state_q == S_JS_LM_W
			|| state_q == S_JS_T1_W || state_q == S_JS_T2_W))
		else $error("log result not awaited");

endmodule

FILE: sim/tb_kl_js_divergence.sv
module tb_kl_js_divergence;
	import kljs_pkg::*;

	localparam int SUM_CAP = 1024 * 131071;
	localparam longint ACC_TOP = 64'sd36028797018963967;
	localparam longint ACC_BOTTOM = -ACC_TOP - 1;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [16:0] p;
		logic [16:0] q;
		logic last;
	} pair_t;

	typedef struct {
		logic [31:0] divergence;
		logic [2:0] status;
	} div_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_MODE;
	logic [16:0] cfg_data = '0;

	kljs_in_if in_ch();
	kljs_out_if out_ch();

	kl_js_divergence DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pair_t pending_pairs[$];
	div_result_t expected_divergences[$];
	int errors = 0;
	int send_idle = 28;
	int recv_idle = 72;
	int stall_count = 0;

	logic js_mode = 1'b0;
	logic [16:0] w_first = 17'd32768;
	logic [16:0] w_second = 17'd32768;
	logic [15:0] tolerance = 16'd1;
	longint unsigned sum_p = 0;
	longint unsigned sum_q = 0;
	longint acc = 0;
	logic zero_den = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned ln_q28(input longint unsigned x);
		int e;
		longint unsigned y;
		longint unsigned lg;
		e = 0;
		if (x == 0) begin
			return 0;
		end
		while (e < 63 && (x >> (e + 1)) != 0) begin
			e++;
		end
		y = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
		lg = longint'(e) << 28;
		for (int i = 27; i >= 0; i--) begin
			y = (y * y) >> 31;
			if (y >= 64'd4294967296) begin
				y = y >> 1;
				lg = lg | (64'd1 << i);
			end
		end
		return (lg * 64'd744261118 + (64'd1 << 29)) >> 30;
	endfunction

	function automatic void add_log_term(input longint unsigned coef,
		input longint unsigned lna, input longint unsigned lnb);
		longint unsigned d;
		longint m;
		d = (lna < lnb) ? lnb - lna : lna - lnb;
		m = longint'((coef * d + 64'd2048) >> 12);
		if (lna < lnb) begin
			acc = (acc < ACC_BOTTOM + m) ? ACC_BOTTOM : acc - m;
		end else begin
			acc = (acc > ACC_TOP - m) ? ACC_TOP : acc + m;
		end
	endfunction

	function automatic bit off_one(input longint unsigned s);
		return s > 65536 + tolerance || s + tolerance < 65536;
	endfunction

	function automatic void predict_pair(input logic [16:0] p, input logic [16:0] q,
		input logic last);
		longint unsigned mix;
		longint unsigned ln_mix;
		longint unsigned r;
		div_result_t res;
		sum_p = (sum_p + p > SUM_CAP) ? SUM_CAP : sum_p + p;
		sum_q = (sum_q + q > SUM_CAP) ? SUM_CAP : sum_q + q;
		if (!js_mode) begin
			if (p > 0) begin
				if (q == 0) begin
					zero_den = 1'b1;
				end else begin
					add_log_term(p, ln_q28(p), ln_q28(q));
				end
			end
		end else begin
			mix = longint'(w_first) * p + longint'(w_second) * q;
			ln_mix = ln_q28(mix);
			if (w_first > 0 && p > 0) begin
				if (mix == 0) begin
					zero_den = 1'b1;
				end else begin
					add_log_term((longint'(w_first) * p + 32768) >> 16,
						ln_q28(longint'(p) << 16), ln_mix);
				end
			end
			if (w_second > 0 && q > 0) begin
				if (mix == 0) begin
					zero_den = 1'b1;
				end else begin
					add_log_term((longint'(w_second) * q + 32768) >> 16,
						ln_q28(longint'(q) << 16), ln_mix);
				end
			end
		end
		if (!last) begin
			return;
		end
		res.divergence = '0;
		if (off_one(sum_p)) begin
			res.status = ST_FIRST_BAD;
		end else if (off_one(sum_q)) begin
			res.status = ST_SECOND_BAD;
		end else if (js_mode && off_one(longint'(w_first) + w_second)) begin
			res.status = ST_BAD_WEIGHTS;
		end else if (zero_den) begin
			res.status = ST_INFINITE;
			res.divergence = 32'hFFFFFFFF;
		end else if (acc < 0) begin
			res.status = ST_NEGATIVE;
		end else begin
			res.status = ST_OK;
			r = (longint'(acc) + 32768) >> 16;
			res.divergence = (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
		end
		expected_divergences = {expected_divergences, res};
		sum_p = 0;
		sum_q = 0;
		acc = 0;
		zero_den = 1'b0;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_pair(in_ch.p_element, in_ch.q_element, in_ch.last_element);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
					pair_t nxt;
					nxt = pending_pairs.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.p_element <= nxt.p;
					in_ch.q_element <= nxt.q;
					in_ch.last_element <= nxt.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_divergences.size() == 0) begin
					$error("divergence: transaction with no result expected, actual %0d",
						out_ch.divergence);
					errors++;
				end else begin
					div_result_t exp_res;
					exp_res = expected_divergences.pop_front();
					if (out_ch.divergence !== exp_res.divergence) begin
						$error("divergence: expected %0d actual %0d",
							exp_res.divergence, out_ch.divergence);
						errors++;
					end
					if (out_ch.status !== exp_res.status) begin
						$error("status: expected %0d actual %0d",
							exp_res.status, out_ch.status);
						errors++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE: js_mode = val[0];
			CFG_WEIGHT_FIRST: w_first = val;
			CFG_WEIGHT_SECOND: w_second = val;
			default: tolerance = val[15:0];
		endcase
	endtask

	task automatic push_pair(input int p, input int q, input bit last);
		pair_t pr;
		pr.p = 17'(p);
		pr.q = 17'(q);
		pr.last = last;
		pending_pairs = {pending_pairs, pr};
	endtask

	// Splits one unit of probability into len parts, with some zero parts.
	task automatic split_unit(input int len, output int parts[$]);
		int left;
		int v;
		parts = {};
		left = 65536;
		for (int i = 0; i < len - 1; i++) begin
			v = ($urandom_range(3) == 0) ? 0 : $urandom_range(left);
			parts = {parts, v};
			left -= v;
		end
		parts = {parts, left};
	endtask

	task automatic push_random_vector();
		int len;
		int kind;
		int ps[$];
		int qs[$];
		len = ($urandom_range(19) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
		kind = $urandom_range(9);
		split_unit(len, ps);
		split_unit(len, qs);
		if (kind == 8) begin
			ps[len - 1] = ps[len - 1] + $urandom_range(6) - 3;
			qs[len - 1] = qs[len - 1] + $urandom_range(6) - 3;
			if (ps[len - 1] < 0) ps[len - 1] = 0;
			if (qs[len - 1] < 0) qs[len - 1] = 0;
		end
		for (int i = 0; i < len; i++) begin
			if (kind == 9) begin
				push_pair($urandom_range(131071), $urandom_range(131071), i == len - 1);
			end else begin
				push_pair(ps[i], qs[i], i == len - 1);
			end
		end
	endtask

	task automatic run_phase(input int item_goal);
		int start_size;
		start_size = pending_pairs.size();
		while (pending_pairs.size() - start_size < item_goal) begin
			push_random_vector();
		end
		wait (pending_pairs.size() == 0 && !in_ch.valid && expected_divergences.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.p_element = '0;
		in_ch.q_element = '0;
		in_ch.last_element = 1'b0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		push_pair(65536, 65536, 1);
		push_pair(32768, 65536, 0);
		push_pair(32768, 0, 1);
		push_pair(0, 0, 0);
		push_pair(65536, 65536, 1);
		push_pair(100, 100, 1);
		push_pair(65536, 100, 1);
		push_pair(1, 65535, 0);
		push_pair(65535, 1, 1);
		push_pair(131071, 131071, 1);
		run_phase(200);

		write_reg(CFG_MODE, 17'd1);
		push_pair(65536, 0, 1);
		push_pair(0, 65536, 0);
		push_pair(65536, 0, 1);
		push_pair(0, 0, 0);
		push_pair(65536, 65536, 1);
		run_phase(200);

		send_idle = 72;
		recv_idle = 28;
		write_reg(CFG_WEIGHT_FIRST, 17'd65536);
		write_reg(CFG_WEIGHT_SECOND, 17'd0);
		write_reg(CFG_SUM_TOLERANCE, 17'd65535);
		run_phase(200);

		write_reg(CFG_WEIGHT_FIRST, 17'd0);
		write_reg(CFG_WEIGHT_SECOND, 17'd65536);
		write_reg(CFG_SUM_TOLERANCE, 17'd0);
		run_phase(200);

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_MODE, 17'd0);
		write_reg(CFG_SUM_TOLERANCE, 17'd65535);
		push_pair(1000, 60000, 1);
		push_pair(0, 131071, 0);
		push_pair(131071, 1, 1);
		run_phase(250);

		write_reg(CFG_MODE, 17'd1);
		write_reg(CFG_WEIGHT_FIRST, 17'd40000);
		write_reg(CFG_WEIGHT_SECOND, 17'd25536);
		write_reg(CFG_SUM_TOLERANCE, 17'd10);
		run_phase(250);

		write_reg(CFG_WEIGHT_FIRST, 17'd1000);
		write_reg(CFG_WEIGHT_SECOND, 17'd20000);
		write_reg(CFG_SUM_TOLERANCE, 17'd100);
		run_phase(60);

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

FILE: sim.f
design/kljs_pkg.sv
design/kljs_in_if.sv
design/kljs_out_if.sv
design/kljs_log.sv
design/kl_js_divergence.sv
sim/tb_kl_js_divergence.sv
